// ===== src/siv_pkg.sv =====
// Package with the shared constants, types and the byte-wide CRC step of the image validator.
`timescale 1ns / 1ps
package siv_pkg;

	localparam int unsigned RECORD_BYTES = 78;
	localparam int unsigned KEY_BYTES    = 32;
	localparam int unsigned SLOT_BYTES   = 4096;

	localparam logic [31:0] CRC_POLY  = 32'hEDB88320;
	localparam logic [31:0] ALL_ONES  = 32'hFFFFFFFF;
	localparam logic [31:0] IMG_MAGIC = 32'h31445243;
	localparam logic [16:0] HDR_BYTES = 17'd16;
	localparam logic [16:0] CRC_BYTES = 17'd4;

	localparam int unsigned IN_QUEUE_DEPTH  = 4;
	localparam int unsigned OUT_QUEUE_DEPTH = 2;

	// Configuration register indexes.
	localparam logic [1:0] REG_MAX_ENTRIES   = 2'd0;
	localparam logic [1:0] REG_MAX_SCOPE     = 2'd1;
	localparam logic [1:0] REG_MAX_STATE     = 2'd2;

	localparam logic [7:0] MAX_ENTRIES_RST = 8'd16;
	localparam logic [7:0] MAX_SCOPE_RST   = 8'd3;
	localparam logic [7:0] MAX_STATE_RST   = 8'd2;

	typedef enum logic [2:0] {
		FAULT_NONE      = 3'd0,
		FAULT_MAGIC     = 3'd1,
		FAULT_VERSION   = 3'd2,
		FAULT_LENGTH    = 3'd3,
		FAULT_TRUNCATED = 3'd4,
		FAULT_CRC       = 3'd5,
		FAULT_RECORD    = 3'd6
	} fault_t;

	typedef struct packed {
		logic [7:0] max_entries;
		logic [7:0] max_scope_kind;
		logic [7:0] max_record_state;
	} cfg_t;

	typedef struct packed {
		logic        image_ok;
		fault_t      fault_code;
		logic [7:0]  entry_count;
		logic [31:0] image_generation;
	} verdict_t;

	typedef struct packed {
		logic [7:0] image_byte;
		logic       end_of_image;
	} in_word_t;

	// One byte of the reflected CRC-32.
	function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {24'd0, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

// ===== src/siv_fifo.sv =====
// Small generic register queue used between the front, the scanner and the result port.
`timescale 1ns / 1ps
module siv_fifo #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);
	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push, do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	// Storage is written at the tail.
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end
endmodule

// ===== src/siv_scan.sv =====
// Back part: runs the CRC and the header and record checks over one byte per cycle in which take is high.
`timescale 1ns / 1ps
module siv_scan import siv_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_t       cfg,
	input  logic       take,
	input  in_word_t   word,
	output logic       verdict_valid,
	output verdict_t   verdict
);
	logic [15:0] pos_q;
	logic [31:0] crc_q, hs_q, gen_q, acc_q, vfrom_q, limit_q;
	logic [7:0]  cnt_q;
	logic [15:0] len_q;
	logic [6:0]  off_q;
	logic        kz_q;
	logic        f_magic_q, f_ver_q, f_len_q, f_crc_q, f_rec_q;

	logic [7:0]  b;
	logic [16:0] pos_x, crc_off, crc_end, slot_lim;
	logic        in_slot, hdr_ok, crc_upd, hs_upd, rec_en;
	logic [31:0] crc_n, hs_n, gen_n, acc_n, vfrom_n, limit_n;
	logic [7:0]  cnt_n;
	logic [15:0] len_n, pos_n;
	logic [14:0] prod;
	logic [6:0]  off_n;
	logic        kz_cur, kz_n, bad;
	logic        f_magic_n, f_ver_n, f_len_n, f_crc_n, f_rec_n;
	logic [16:0] need_end;
	fault_t      code;

	assign b        = word.image_byte;
	assign pos_x    = {1'b0, pos_q};
	assign slot_lim = 17'(SLOT_BYTES);
	assign in_slot  = pos_x < slot_lim;
	assign crc_off  = HDR_BYTES + {1'b0, len_q};
	assign crc_end  = crc_off + CRC_BYTES;
	assign hdr_ok   = (pos_q >= 16'd14) && !(f_magic_q || f_ver_q || f_len_q);
	assign prod     = 15'(cnt_q) * 15'(RECORD_BYTES);

	// Header fields, CRC and image-level checks.
	always_comb begin
		crc_upd   = in_slot && (pos_q < 16'd16 || (hdr_ok && pos_x < crc_off));
		hs_upd    = in_slot && (pos_q < 16'd16 || (hdr_ok && pos_x < crc_end));
		crc_n     = crc_upd ? crc_byte(crc_q, b) : crc_q;
		hs_n      = hs_upd ? {b, hs_q[31:8]} : hs_q;
		f_magic_n = f_magic_q;
		f_ver_n   = f_ver_q;
		f_len_n   = f_len_q;
		f_crc_n   = f_crc_q;
		cnt_n     = cnt_q;
		gen_n     = gen_q;
		len_n     = len_q;
		if (in_slot && pos_q == 16'd3 && hs_n != IMG_MAGIC) f_magic_n = 1'b1;
		if (in_slot && pos_q == 16'd5 && hs_n[31:16] != 16'd1) f_ver_n = 1'b1;
		if (in_slot && pos_q == 16'd6) cnt_n = b;
		if (in_slot && pos_q == 16'd11) gen_n = hs_n;
		if (in_slot && pos_q == 16'd13) begin
			len_n = hs_n[31:16];
			if (cnt_q > cfg.max_entries || len_n != {1'b0, prod} ||
			    (HDR_BYTES + {1'b0, len_n} + CRC_BYTES) > slot_lim) begin
				f_len_n = 1'b1;
			end
		end
		if (in_slot && hdr_ok && pos_x == crc_end - 17'd1 && hs_n != ~crc_q) begin
			f_crc_n = 1'b1;
		end
		pos_n = (pos_q == 16'hFFFF) ? pos_q : pos_q + 16'd1;
	end

	// Record field checks.
	always_comb begin
		rec_en  = in_slot && hdr_ok && pos_q >= 16'd16 && pos_x < crc_off;
		acc_n   = {b, acc_q[31:8]};
		vfrom_n = vfrom_q;
		limit_n = limit_q;
		bad     = 1'b0;
		kz_cur  = (off_q == 7'd0) ? 1'b1 : kz_q;
		kz_n    = kz_cur;
		if ((off_q == 7'd3 || off_q == 7'd7 || off_q == 7'd36 || off_q == 7'd40) &&
		    acc_n == '0) bad = 1'b1;
		if (off_q == 7'd8 && b > cfg.max_scope_kind) bad = 1'b1;
		if (off_q == 7'd16) vfrom_n = acc_n;
		if (off_q == 7'd20 && acc_n != '0 && vfrom_q > acc_n) bad = 1'b1;
		if (off_q == 7'd28) begin
			limit_n = acc_n;
			if (acc_n == '0) bad = 1'b1;
		end
		if (off_q == 7'd32 && acc_n > limit_q) bad = 1'b1;
		if (off_q >= 7'd41 && off_q < 7'(41 + KEY_BYTES)) begin
			if (b != 8'd0) kz_n = 1'b0;
			if (off_q == 7'(40 + KEY_BYTES) && kz_n) bad = 1'b1;
		end
		if (off_q == 7'd73 && b > cfg.max_record_state) bad = 1'b1;
		off_n   = (off_q == 7'(RECORD_BYTES - 1)) ? 7'd0 : off_q + 7'd1;
		f_rec_n = f_rec_q || (rec_en && bad);
	end

	// Verdict with fixed priority among the faults.
	always_comb begin
		need_end = HDR_BYTES + {1'b0, len_n} + CRC_BYTES;
		if (f_magic_n) code = FAULT_MAGIC;
		else if (f_ver_n) code = FAULT_VERSION;
		else if (f_len_n) code = FAULT_LENGTH;
		else if (pos_n < 16'd14 || {1'b0, pos_n} < need_end) code = FAULT_TRUNCATED;
		else if (f_crc_n) code = FAULT_CRC;
		else if (f_rec_n) code = FAULT_RECORD;
		else code = FAULT_NONE;
		verdict_valid            = take && word.end_of_image;
		verdict.image_ok         = (code == FAULT_NONE);
		verdict.fault_code       = code;
		verdict.entry_count      = (code == FAULT_NONE) ? cnt_n : 8'd0;
		verdict.image_generation = (code == FAULT_NONE) ? gen_n : 32'd0;
	end

	// Scan state; cleared after each verdict.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0; crc_q <= ALL_ONES; hs_q <= '0; cnt_q <= '0; len_q <= '0;
			gen_q <= '0; off_q <= '0; acc_q <= '0; vfrom_q <= '0; limit_q <= '0;
			kz_q <= 1'b1; f_magic_q <= 1'b0; f_ver_q <= 1'b0; f_len_q <= 1'b0;
			f_crc_q <= 1'b0; f_rec_q <= 1'b0;
		end else if (take) begin
			if (word.end_of_image) begin
				pos_q <= '0; crc_q <= ALL_ONES; hs_q <= '0; cnt_q <= '0; len_q <= '0;
				gen_q <= '0; off_q <= '0; acc_q <= '0; vfrom_q <= '0; limit_q <= '0;
				kz_q <= 1'b1; f_magic_q <= 1'b0; f_ver_q <= 1'b0; f_len_q <= 1'b0;
				f_crc_q <= 1'b0; f_rec_q <= 1'b0;
			end else begin
				pos_q <= pos_n; crc_q <= crc_n; hs_q <= hs_n; cnt_q <= cnt_n;
				len_q <= len_n; gen_q <= gen_n;
				f_magic_q <= f_magic_n; f_ver_q <= f_ver_n; f_len_q <= f_len_n;
				f_crc_q <= f_crc_n; f_rec_q <= f_rec_n;
				if (rec_en) begin
					acc_q <= acc_n; vfrom_q <= vfrom_n; limit_q <= limit_n;
					kz_q <= kz_n; off_q <= off_n;
				end
			end
		end
	end
endmodule

// ===== src/store_image_validator_core.sv =====
// Top level of the slot image validator: byte queue, scanner and verdict queue.
`timescale 1ns / 1ps
// Usage:
// Image bytes enter through a queue-style port: image_byte with end_of_image
// is taken at a clock edge where push is high and full is low. Every byte of
// an image is pushed in order from offset zero; the byte with end_of_image set
// closes the image and produces exactly one verdict word.
// Verdicts leave through a second queue port: while empty is low the oldest
// verdict (image_ok, fault_code, entry_count, image_generation) is on the
// ports, and it is taken at an edge where pop is high.
// Throughput is one byte per cycle while the verdict queue is not full, set
// by the byte-wide CRC step in the scanner. A byte is stored in the input
// queue and is scanned in the cycle it leaves it; its verdict is registered
// in the verdict queue and is visible from there.
// If pop stays low, the verdict queue fills and the scanner stops draining
// the input queue, which then raises full; nothing is lost.
// Reset clears both queues and the scan state and restores the limits to 16
// entries, scope kind 3, record state 2. The user must write configuration
// via cfg_write_en, cfg_index, cfg_data while the block is idle; not enforced.
module store_image_validator_core import siv_pkg::*; #(
	parameter int unsigned IN_DEPTH  = IN_QUEUE_DEPTH,
	parameter int unsigned OUT_DEPTH = OUT_QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_write_en,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  image_byte,
	input  logic        end_of_image,
	output logic        empty,
	input  logic        pop,
	output logic        image_ok,
	output logic [2:0]  fault_code,
	output logic [7:0]  entry_count,
	output logic [31:0] image_generation
);
	cfg_t     cfg_q;
	in_word_t in_w, q_w;
	logic     q_empty, take, v_valid, v_full;
	verdict_t v_in, v_out;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_entries      <= MAX_ENTRIES_RST;
			cfg_q.max_scope_kind   <= MAX_SCOPE_RST;
			cfg_q.max_record_state <= MAX_STATE_RST;
		end else if (cfg_write_en) begin
			case (cfg_index)
				REG_MAX_ENTRIES: cfg_q.max_entries      <= cfg_data;
				REG_MAX_SCOPE:   cfg_q.max_scope_kind   <= cfg_data;
				REG_MAX_STATE:   cfg_q.max_record_state <= cfg_data;
				default: ;
			endcase
		end
	end

	// Front: byte queue.
	assign in_w.image_byte   = image_byte;
	assign in_w.end_of_image = end_of_image;

	siv_fifo #(.WIDTH($bits(in_word_t)), .DEPTH(IN_DEPTH)) u_in_q (
		.clk(clk), .arst_n(arst_n), .push(push), .wdata(in_w), .full(full),
		.pop(take), .rdata(q_w), .empty(q_empty)
	);

	// The scanner takes a word whenever one is queued and a verdict slot is free.
	assign take = !q_empty && !v_full;

	siv_scan u_scan (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_q), .take(take), .word(q_w),
		.verdict_valid(v_valid), .verdict(v_in)
	);

	// Back: verdict queue.
	siv_fifo #(.WIDTH($bits(verdict_t)), .DEPTH(OUT_DEPTH)) u_out_q (
		.clk(clk), .arst_n(arst_n), .push(v_valid), .wdata(v_in), .full(v_full),
		.pop(pop), .rdata(v_out), .empty(empty)
	);

	assign image_ok         = v_out.image_ok;
	assign fault_code       = v_out.fault_code;
	assign entry_count      = v_out.entry_count;
	assign image_generation = v_out.image_generation;
endmodule
